>>> sv/psg_pkg.sv
package psg_pkg;

	// Transaction codes of the command channel.
	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_CTRL   = 2'd1,
		FUNC_STEREO = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// Noise rate select codes.
	localparam logic [1:0] RATE_16    = 2'd0;
	localparam logic [1:0] RATE_32    = 2'd1;
	localparam logic [1:0] RATE_64    = 2'd2;
	localparam logic [1:0] RATE_TONE2 = 2'd3;

	localparam logic [1:0] NOISE_CHANNEL = 2'd3;
	localparam logic [3:0] ATTEN_SILENT = 4'd15;
	localparam logic [15:0] LFSR_SEED = 16'h0080;
	localparam logic [9:0] NOISE_RELOAD_RESET = 10'd16;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [16:0] left_level;
		logic [16:0] right_level;
		logic [3:0]  tone0_atten;
		logic [3:0]  tone1_atten;
		logic [3:0]  tone2_atten;
		logic [3:0]  noise_atten;
	} sample_t;

	// Attenuations of one tick with the stereo enables in force at that tick.
	typedef struct packed {
		logic [3:0][3:0] atten;
		logic [3:0]      left_en;
		logic [3:0]      right_en;
	} tick_t;

	// Output level for an attenuation code, unsigned Q0.16.
	function automatic logic [14:0] level_q16(input logic [3:0] atten);
		logic [14:0] lvl;
		case (atten)
			4'd0:    lvl = 15'd16384;
			4'd1:    lvl = 15'd13014;
			4'd2:    lvl = 15'd10338;
			4'd3:    lvl = 15'd8211;
			4'd4:    lvl = 15'd6523;
			4'd5:    lvl = 15'd5181;
			4'd6:    lvl = 15'd4115;
			4'd7:    lvl = 15'd3269;
			4'd8:    lvl = 15'd2597;
			4'd9:    lvl = 15'd2063;
			4'd10:   lvl = 15'd1638;
			4'd11:   lvl = 15'd1301;
			4'd12:   lvl = 15'd1034;
			4'd13:   lvl = 15'd821;
			4'd14:   lvl = 15'd652;
			default: lvl = 15'd0;
		endcase
		return lvl;
	endfunction

endpackage

>>> sv/psg_core.sv
module psg_core import psg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  cmd_t  cmd,
	output tick_t tick
);

	logic [2:0][9:0] tone_period_q, tone_period_d;
	logic [2:0][9:0] tone_count_q, tone_count_d;
	logic [2:0]      tone_phase_q, tone_phase_d;
	logic [2:0][3:0] tone_volume_q, tone_volume_d;
	logic [1:0]      noise_rate_sel_q, noise_rate_sel_d;
	logic            noise_white_q, noise_white_d;
	logic [9:0]      noise_count_q, noise_count_d;
	logic [9:0]      noise_reload_q, noise_reload_d;
	logic [15:0]     noise_lfsr_q, noise_lfsr_d;
	logic [3:0]      noise_volume_q, noise_volume_d;
	logic            noise_phase_q, noise_phase_d;
	logic [1:0]      latched_channel_q, latched_channel_d;
	logic            latched_is_volume_q, latched_is_volume_d;
	logic [3:0]      left_enable_q, left_enable_d;
	logic [3:0]      right_enable_q, right_enable_d;

	logic [2:0] tone_event;
	logic [2:0] tone_phase_nx;
	logic       noise_event;
	logic       noise_phase_nx;
	logic       noise_fire;
	logic [15:0] lfsr_shifted;
	logic [9:0] reload_sel;
	logic [1:0] ch;
	logic [7:0] d;

	assign d = cmd.data;

	// Tick datapath: each counter fires when it is zero or about to reach zero.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tone_event[k] = (tone_count_q[k] == 10'd0) || (tone_count_q[k] == 10'd1);
			tone_phase_nx[k] = tone_phase_q[k] ^
				(tone_event[k] && (tone_period_q[k] > 10'd1));
			tick.atten[k] = ((tone_period_q[k] <= 10'd1) || tone_phase_nx[k]) ?
				tone_volume_q[k] : ATTEN_SILENT;
		end
		noise_event = (noise_count_q == 10'd0) || (noise_count_q == 10'd1);
		if (noise_reload_q <= 10'd1) begin
			noise_phase_nx = noise_phase_q;
			noise_fire = noise_event && !noise_phase_q;
		end else begin
			noise_phase_nx = noise_phase_q ^ noise_event;
			noise_fire = noise_event && !noise_phase_q;
		end
		lfsr_shifted = {noise_lfsr_q[14:0],
			noise_lfsr_q[15] ^ (noise_white_q & noise_lfsr_q[12])};
		case (noise_rate_sel_q)
			RATE_16: reload_sel = 10'd16;
			RATE_32: reload_sel = 10'd32;
			RATE_64: reload_sel = 10'd64;
			default: reload_sel = tone_period_q[2];
		endcase
		tick.atten[3] = (noise_fire ? lfsr_shifted[7] : noise_lfsr_q[7]) ?
			noise_volume_q : ATTEN_SILENT;
		tick.left_en = left_enable_q;
		tick.right_en = right_enable_q;
	end

	// Next state for the accepted command.
	always_comb begin
		tone_period_d = tone_period_q;
		tone_count_d = tone_count_q;
		tone_phase_d = tone_phase_q;
		tone_volume_d = tone_volume_q;
		noise_rate_sel_d = noise_rate_sel_q;
		noise_white_d = noise_white_q;
		noise_count_d = noise_count_q;
		noise_reload_d = noise_reload_q;
		noise_lfsr_d = noise_lfsr_q;
		noise_volume_d = noise_volume_q;
		noise_phase_d = noise_phase_q;
		latched_channel_d = latched_channel_q;
		latched_is_volume_d = latched_is_volume_q;
		left_enable_d = left_enable_q;
		right_enable_d = right_enable_q;
		ch = d[7] ? d[6:5] : latched_channel_q;
		if (go) begin
			unique case (func_t'(cmd.func))
				FUNC_TICK: begin
					for (int k = 0; k < 3; k++) begin
						tone_phase_d[k] = tone_phase_nx[k];
						tone_count_d[k] = tone_event[k] ? tone_period_q[k] :
							tone_count_q[k] - 10'd1;
					end
					if (noise_event) begin
						noise_phase_d = noise_phase_nx;
						noise_reload_d = reload_sel;
						noise_count_d = reload_sel;
						if (noise_fire)
							noise_lfsr_d = lfsr_shifted;
					end else begin
						noise_count_d = noise_count_q - 10'd1;
					end
				end
				FUNC_CTRL: begin
					if (d[7]) begin
						latched_channel_d = d[6:5];
						latched_is_volume_d = d[4];
					end
					if (d[7] && d[4]) begin
						if (ch != NOISE_CHANNEL)
							tone_volume_d[ch] = d[3:0];
						else
							noise_volume_d = d[3:0];
					end else if (d[7] || !latched_is_volume_q) begin
						if (ch == NOISE_CHANNEL) begin
							noise_rate_sel_d = d[1:0];
							noise_white_d = d[2];
							if (!d[2])
								noise_lfsr_d = LFSR_SEED;
						end else if (d[7]) begin
							tone_period_d[ch] = {tone_period_q[ch][9:4], d[3:0]};
						end else begin
							tone_period_d[ch] = {d[5:0], tone_period_q[ch][3:0]};
						end
					end
				end
				FUNC_STEREO: begin
					right_enable_d = d[3:0];
					left_enable_d = d[7:4];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_period_q <= '0;
			tone_count_q <= '0;
			tone_phase_q <= '0;
			tone_volume_q <= {3{ATTEN_SILENT}};
			noise_rate_sel_q <= RATE_16;
			noise_white_q <= 1'b0;
			noise_count_q <= NOISE_RELOAD_RESET;
			noise_reload_q <= NOISE_RELOAD_RESET;
			noise_lfsr_q <= LFSR_SEED;
			noise_volume_q <= ATTEN_SILENT;
			noise_phase_q <= 1'b0;
			latched_channel_q <= '0;
			latched_is_volume_q <= 1'b0;
			left_enable_q <= 4'hF;
			right_enable_q <= 4'hF;
		end else begin
			tone_period_q <= tone_period_d;
			tone_count_q <= tone_count_d;
			tone_phase_q <= tone_phase_d;
			tone_volume_q <= tone_volume_d;
			noise_rate_sel_q <= noise_rate_sel_d;
			noise_white_q <= noise_white_d;
			noise_count_q <= noise_count_d;
			noise_reload_q <= noise_reload_d;
			noise_lfsr_q <= noise_lfsr_d;
			noise_volume_q <= noise_volume_d;
			noise_phase_q <= noise_phase_d;
			latched_channel_q <= latched_channel_d;
			latched_is_volume_q <= latched_is_volume_d;
			left_enable_q <= left_enable_d;
			right_enable_q <= right_enable_d;
		end
	end

	// The noise register starts nonzero and its shift is invertible.
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		noise_lfsr_q != 16'd0)
		else $error("noise shift register reached zero");

endmodule

>>> sv/psg_mix.sv
module psg_mix import psg_pkg::*; (
	input  tick_t   tick,
	output sample_t smp
);

	logic [3:0][14:0] lvl;
	logic [16:0] left_sum;
	logic [16:0] right_sum;

	always_comb begin
		left_sum = '0;
		right_sum = '0;
		for (int k = 0; k < 4; k++) begin
			lvl[k] = level_q16(tick.atten[k]);
			if (tick.left_en[k])
				left_sum = left_sum + {2'b00, lvl[k]};
			if (tick.right_en[k])
				right_sum = right_sum + {2'b00, lvl[k]};
		end
		smp.left_level = left_sum;
		smp.right_level = right_sum;
		smp.tone0_atten = tick.atten[0];
		smp.tone1_atten = tick.atten[1];
		smp.tone2_atten = tick.atten[2];
		smp.noise_atten = tick.atten[3];
	end

endmodule

>>> sv/programmable_sound_generator.sv
// A sample tick goes through the input register, the channel update into stage two
// and the mixing into the output register. Throughput: one transaction per cycle
// unless a tick is stalled; control and stereo writes produce no sample.
// Reset (arst_n low, asynchronous) silences all channels, clears the tone periods,
// seeds the noise register with 0x80 and enables every channel on both sides.
module programmable_sound_generator import psg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	output logic    sample_valid,
	input  logic    sample_ready,
	output sample_t sample
);

	// Stage one holds the accepted transaction. The channel state advances
	// when it leaves stage one; a tick then parks its attenuations in stage
	// two, and the mixer fills the output register from stage two. Each
	// stage moves whenever the stage after it is empty or moving. While a
	// sample waits, writes keep retiring and one more tick can enter stage
	// two; the input stalls only once a further tick sits in stage one.
	logic    valid_s1;
	cmd_t    cmd_s1;
	logic    valid_s2;
	tick_t   tick_s2;
	logic    out_valid_q;
	sample_t out_q;

	tick_t   tick_c;
	sample_t mix_c;
	logic    adv_out;
	logic    s2_free;
	logic    s1_is_tick;
	logic    s1_go;

	assign adv_out = !out_valid_q || sample_ready;
	assign s2_free = !valid_s2 || adv_out;
	assign s1_is_tick = (func_t'(cmd_s1.func) == FUNC_TICK);
	// Writes retire from stage one at once; a tick needs room in stage two.
	assign s1_go = valid_s1 && (!s1_is_tick || s2_free);
	assign cmd_ready = !valid_s1 || s1_go;

	psg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (s1_go),
		.cmd    (cmd_s1),
		.tick   (tick_c)
	);

	psg_mix u_mix (
		.tick (tick_s2),
		.smp  (mix_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_ready)
				valid_s1 <= cmd_valid;
			if (s2_free)
				valid_s2 <= s1_go && s1_is_tick;
			if (adv_out)
				out_valid_q <= valid_s2;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid)
			cmd_s1 <= cmd;
		if (s1_go && s1_is_tick)
			tick_s2 <= tick_c;
		if (adv_out && valid_s2)
			out_q <= mix_c;
	end

	assign sample_valid = out_valid_q;
	assign sample = out_q;

	// A write that retires while stage two drains must not create a sample.
	a_write_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !s1_is_tick && s2_free) |=> !valid_s2)
		else $error("write produced a sample");

	// A tick held in stage two is neither lost nor overwritten.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv_out) |=> (valid_s2 && $stable(tick_s2)))
		else $error("stage two tick lost while output stalled");

	// Four silent channels mix to zero on both sides.
	a_silent_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.tone0_atten == ATTEN_SILENT
			&& out_q.tone1_atten == ATTEN_SILENT
			&& out_q.tone2_atten == ATTEN_SILENT
			&& out_q.noise_atten == ATTEN_SILENT)
		|-> (out_q.left_level == 17'd0 && out_q.right_level == 17'd0))
		else $error("silent channels mixed to a nonzero level");

	// Four channels at full volume sum to at most unity.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.left_level <= 17'd65536 && out_q.right_level <= 17'd65536))
		else $error("mixed level above unity");

endmodule

>>> tb/sv/tb.sv
module tb;
	import psg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Length of the hold-off that the sample channel takes at two points in the run, so
	// that the pipeline fills up and the command channel has to stall.
	localparam int unsigned LONG_HOLD = 150;

	// One entry of the sender's queue. A pause entry sends nothing. Instead the sender waits
	// until every sample it has caused so far has come back.
	typedef struct {
		cmd_t        cmd;
		int unsigned gap;
		bit          pause;
	} pending_cmd_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cmd_valid = 1'b0;
	logic    cmd_ready;
	cmd_t    cmd = '0;
	logic    sample_valid;
	logic    sample_ready = 1'b0;
	sample_t sample;

	pending_cmd_t pending_cmds[$];
	sample_t      expected_samples[$];

	// Shadow copy of the generator state, advanced as transactions are accepted.
	logic [9:0]  tone_per [3];
	logic [9:0]  tone_cnt [3];
	logic        tone_ph [3];
	logic [3:0]  tone_vol [3];
	logic [1:0]  nz_rate;
	logic        nz_white;
	logic [9:0]  nz_cnt;
	logic [9:0]  nz_reload;
	logic [15:0] nz_sr;
	logic [3:0]  nz_vol;
	logic        nz_ph;
	logic [1:0]  latch_ch;
	logic        latch_vol;
	logic [3:0]  left_en;
	logic [3:0]  right_en;

	int unsigned error_count = 0;
	int unsigned ticks_sent = 0;
	int unsigned writes_sent = 0;
	int unsigned samples_checked = 0;
	int unsigned noise_shifts = 0;
	int unsigned tone_flips = 0;
	int unsigned tx_gap_max = 0;

	programmable_sound_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Level in unsigned Q0.16 for an attenuation code; code 15 is silence.
	function automatic logic [16:0] atten_to_level(input logic [3:0] att);
		case (att)
			4'd0:    return 17'd16384;
			4'd1:    return 17'd13014;
			4'd2:    return 17'd10338;
			4'd3:    return 17'd8211;
			4'd4:    return 17'd6523;
			4'd5:    return 17'd5181;
			4'd6:    return 17'd4115;
			4'd7:    return 17'd3269;
			4'd8:    return 17'd2597;
			4'd9:    return 17'd2063;
			4'd10:   return 17'd1638;
			4'd11:   return 17'd1301;
			4'd12:   return 17'd1034;
			4'd13:   return 17'd821;
			4'd14:   return 17'd652;
			default: return 17'd0;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("sample %0d field %s is %0d, predicted %0d",
				samples_checked, name, got, want));
	endtask

	// Noise mode comes from either a latch byte or a data byte. Selecting periodic
	// feedback reseeds the shift register.
	task automatic write_noise_mode(input logic [7:0] d);
		nz_rate = d[1:0];
		nz_white = d[2];
		if (!nz_white)
			nz_sr = LFSR_SEED;
	endtask

	// One sample tick: every counter steps once and the mixed sample is queued as the
	// next expected result.
	task automatic advance_channels();
		logic [3:0]  att [4];
		logic [16:0] lsum;
		logic [16:0] rsum;
		logic        expired;
		logic        fire;
		sample_t     s;
		int          k;
		for (k = 0; k < 3; k++) begin
			expired = (tone_cnt[k] == 10'd0);
			if (!expired) begin
				tone_cnt[k] = tone_cnt[k] - 10'd1;
				expired = (tone_cnt[k] == 10'd0);
			end
			if (expired) begin
				if (tone_per[k] > 10'd1) begin
					tone_ph[k] = ~tone_ph[k];
					tone_flips++;
				end
				tone_cnt[k] = tone_per[k];
			end
			// Periods of 0 and 1 hold the output at the channel volume.
			att[k] = (tone_per[k] <= 10'd1 || tone_ph[k]) ? tone_vol[k] : ATTEN_SILENT;
		end

		expired = (nz_cnt == 10'd0);
		if (!expired) begin
			nz_cnt = nz_cnt - 10'd1;
			expired = (nz_cnt == 10'd0);
		end
		if (expired) begin
			if (nz_reload <= 10'd1) begin
				fire = ~nz_ph;
			end else begin
				nz_ph = ~nz_ph;
				fire = nz_ph;
			end
			if (fire) begin
				nz_sr = {nz_sr[14:0], nz_sr[15] ^ (nz_white & nz_sr[12])};
				noise_shifts++;
			end
			case (nz_rate)
				RATE_16: nz_reload = 10'd16;
				RATE_32: nz_reload = 10'd32;
				RATE_64: nz_reload = 10'd64;
				default: nz_reload = tone_per[2];
			endcase
			nz_cnt = nz_reload;
		end
		att[3] = nz_sr[7] ? nz_vol : ATTEN_SILENT;

		lsum = '0;
		rsum = '0;
		for (k = 0; k < 4; k++) begin
			if (left_en[k])
				lsum = lsum + atten_to_level(att[k]);
			if (right_en[k])
				rsum = rsum + atten_to_level(att[k]);
		end
		s.left_level = lsum;
		s.right_level = rsum;
		s.tone0_atten = att[0];
		s.tone1_atten = att[1];
		s.tone2_atten = att[2];
		s.noise_atten = att[3];
		expected_samples.push_back(s);
	endtask

	// Updates the shadow state for one accepted command transaction.
	task automatic apply_command(input cmd_t c);
		logic [7:0] d;
		d = c.data;
		case (c.func)
			FUNC_TICK: begin
				ticks_sent++;
				advance_channels();
			end
			FUNC_CTRL: begin
				writes_sent++;
				if (d[7]) begin
					// Latch byte: picks the channel and register type, then writes the
					// low part of that register at once.
					latch_ch = d[6:5];
					latch_vol = d[4];
					if (latch_vol) begin
						if (latch_ch != NOISE_CHANNEL)
							tone_vol[latch_ch] = d[3:0];
						else
							nz_vol = d[3:0];
					end else if (latch_ch != NOISE_CHANNEL) begin
						tone_per[latch_ch][3:0] = d[3:0];
					end else begin
						write_noise_mode(d);
					end
				end else if (!latch_vol) begin
					// Data byte: the upper six period bits, or the noise mode again.
					// With a volume latched it has no effect at all.
					if (latch_ch != NOISE_CHANNEL)
						tone_per[latch_ch][9:4] = d[5:0];
					else
						write_noise_mode(d);
				end
			end
			FUNC_STEREO: begin
				writes_sent++;
				right_en = d[3:0];
				left_en = d[7:4];
			end
			default: begin
				// The unused code is dropped without a sample.
			end
		endcase
	endtask

	task automatic push_cmd(input func_t f, input logic [7:0] d);
		pending_cmd_t p;
		p.cmd.func = f;
		p.cmd.data = d;
		p.gap = $urandom_range(0, tx_gap_max);
		p.pause = 1'b0;
		pending_cmds.push_back(p);
	endtask

	task automatic push_pause();
		pending_cmd_t p;
		p.cmd = '0;
		p.gap = 0;
		p.pause = 1'b1;
		pending_cmds.push_back(p);
	endtask

	// Command driver. Once an item is on the bus it stays there until cmd_ready takes it.
	// Each item carries its own idle gap, drawn when the queue was filled, and a pause
	// entry holds the bus idle until the expected-sample queue has drained. The shadow
	// model is stepped in this block at the edge where the transaction is accepted.
	always @(posedge clk or negedge arst_n) begin : sender
		pending_cmd_t nxt;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && cmd_ready)
				apply_command(cmd);
			if (!cmd_valid || cmd_ready) begin
				if (pending_cmds.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (pending_cmds[0].pause) begin
					cmd_valid <= 1'b0;
					if (expected_samples.size() == 0)
						void'(pending_cmds.pop_front());
				end else if (pending_cmds[0].gap != 0) begin
					cmd_valid <= 1'b0;
					pending_cmds[0].gap = pending_cmds[0].gap - 1;
				end else begin
					nxt = pending_cmds.pop_front();
					cmd <= nxt.cmd;
					cmd_valid <= 1'b1;
				end
			end
		end
	end

	// Sample monitor. Every accepted sample is compared field by field with the oldest
	// prediction. After each sample the receiver draws a random stall, except in every
	// third stretch of 100 samples, where it draws none. At two points it takes the long
	// hold-off set by LONG_HOLD, so that back-pressure reaches the command side.
	always @(posedge clk or negedge arst_n) begin : receiver
		int unsigned rx_wait;
		int unsigned wait_n;
		sample_t     want;
		if (!arst_n) begin
			sample_ready <= 1'b0;
			rx_wait = 0;
		end else if (sample_valid && sample_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("sample arrived with no tick outstanding");
			end else begin
				want = expected_samples.pop_front();
				compare_field("left_level", 32'(sample.left_level),
					32'(want.left_level));
				compare_field("right_level", 32'(sample.right_level),
					32'(want.right_level));
				compare_field("tone0_atten", 32'(sample.tone0_atten),
					32'(want.tone0_atten));
				compare_field("tone1_atten", 32'(sample.tone1_atten),
					32'(want.tone1_atten));
				compare_field("tone2_atten", 32'(sample.tone2_atten),
					32'(want.tone2_atten));
				compare_field("noise_atten", 32'(sample.noise_atten),
					32'(want.noise_atten));
			end
			samples_checked++;
			if (samples_checked == 150 || samples_checked == 450)
				wait_n = LONG_HOLD;
			else if ((samples_checked / 100) % 3 == 1)
				wait_n = 0;
			else
				wait_n = $urandom_range(0, 8);
			rx_wait = wait_n;
			sample_ready <= (wait_n == 0);
		end else if (rx_wait != 0) begin
			rx_wait = rx_wait - 1;
			sample_ready <= (rx_wait == 0);
		end else begin
			sample_ready <= 1'b1;
		end
	end

	initial begin : run
		int unsigned counted;
		int unsigned phase;
		int unsigned pick;
		int unsigned n;
		int          k;
		logic [1:0]  ch;
		logic [9:0]  per;

		// Power-on contents of the shadow model.
		for (k = 0; k < 3; k++) begin
			tone_per[k] = '0;
			tone_cnt[k] = '0;
			tone_ph[k] = 1'b0;
			tone_vol[k] = ATTEN_SILENT;
		end
		nz_rate = RATE_16;
		nz_white = 1'b0;
		nz_cnt = NOISE_RELOAD_RESET;
		nz_reload = NOISE_RELOAD_RESET;
		nz_sr = LFSR_SEED;
		nz_vol = ATTEN_SILENT;
		nz_ph = 1'b0;
		latch_ch = 2'd0;
		latch_vol = 1'b0;
		left_en = 4'hF;
		right_en = 4'hF;

		// Directed opening: the reset state, the unused code, each channel's volume and
		// period at the extremes (1023, 1, 2), noise in white mode clocked from tone 2,
		// a data byte that lands on a latched volume and is ignored, periodic mode set
		// by a data byte, and stereo enables all off and all on.
		tx_gap_max = 2;
		push_cmd(FUNC_TICK, 8'h00);
		push_cmd(FUNC_NONE, 8'hFF);
		push_cmd(FUNC_CTRL, 8'h90);
		push_cmd(FUNC_TICK, 8'hFF);
		push_cmd(FUNC_CTRL, 8'h8F);
		push_cmd(FUNC_CTRL, 8'h7F);
		push_cmd(FUNC_CTRL, 8'hB7);
		push_cmd(FUNC_CTRL, 8'hA1);
		push_cmd(FUNC_CTRL, 8'h00);
		push_cmd(FUNC_CTRL, 8'hDE);
		push_cmd(FUNC_CTRL, 8'hC2);
		push_cmd(FUNC_CTRL, 8'h00);
		push_cmd(FUNC_CTRL, 8'hF0);
		push_cmd(FUNC_CTRL, 8'hE7);
		push_cmd(FUNC_TICK, 8'h55);
		push_cmd(FUNC_CTRL, 8'hF3);
		push_cmd(FUNC_CTRL, 8'h05);
		push_cmd(FUNC_TICK, 8'hAA);
		push_cmd(FUNC_CTRL, 8'hE4);
		push_cmd(FUNC_CTRL, 8'h01);
		push_cmd(FUNC_TICK, 8'h00);
		push_cmd(FUNC_STEREO, 8'h00);
		push_cmd(FUNC_TICK, 8'h00);
		push_cmd(FUNC_STEREO, 8'hFF);
		push_cmd(FUNC_TICK, 8'h00);
		push_pause();

		// Random part, built from well-formed register sequences and bursts of ticks.
		// The sender's idle pattern changes every 120 items, and every third change it
		// pauses until all samples so far have returned.
		counted = 0;
		phase = 0;
		while (counted < 1100) begin
			if (counted / 120 != phase) begin
				phase = counted / 120;
				case (phase % 3)
					0: tx_gap_max = 8;
					1: tx_gap_max = 0;
					default: tx_gap_max = 3;
				endcase
				if (phase % 3 == 0)
					push_pause();
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = $urandom_range(1, 12);
				repeat (n) push_cmd(FUNC_TICK, 8'($urandom));
				counted += n;
			end else if (pick < 60) begin
				// Tone period: mostly short periods so the outputs toggle often.
				ch = 2'($urandom_range(0, 2));
				n = $urandom_range(0, 9);
				if (n < 6)
					per = 10'($urandom_range(0, 24));
				else if (n < 8)
					per = 10'($urandom);
				else if (n == 8)
					per = 10'd1023;
				else
					per = 10'($urandom_range(0, 1));
				push_cmd(FUNC_CTRL, {1'b1, ch, 1'b0, per[3:0]});
				counted++;
				if ($urandom_range(0, 4) != 0) begin
					push_cmd(FUNC_CTRL, {1'b0, 1'($urandom), per[9:4]});
					counted++;
				end
			end else if (pick < 72) begin
				push_cmd(FUNC_CTRL, {1'b1, 2'($urandom), 1'b1, 4'($urandom)});
				counted++;
			end else if (pick < 80) begin
				// Noise mode by latch, sometimes followed by a data byte that
				// rewrites it.
				push_cmd(FUNC_CTRL, {4'b1110, 4'($urandom)});
				counted++;
				if ($urandom_range(0, 2) == 0) begin
					push_cmd(FUNC_CTRL, {1'b0, 7'($urandom)});
					counted++;
				end
			end else if (pick < 86) begin
				push_cmd(FUNC_STEREO, 8'($urandom));
				counted++;
			end else if (pick < 92) begin
				push_cmd(FUNC_CTRL, {1'b0, 7'($urandom)});
				counted++;
			end else if (pick < 95) begin
				push_cmd(FUNC_NONE, 8'($urandom));
			end else begin
				push_cmd(FUNC_CTRL, 8'($urandom));
				counted++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled on the falling edge, where nothing in the bench is changing.
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || expected_samples.size() != 0);
		// Then keep waiting, to catch any sample the block sends without a tick.
		repeat (12) @(negedge clk);

		$display("Run covered %0d ticks and %0d register writes; %0d samples checked.",
			ticks_sent, writes_sent, samples_checked);
		$display("Tone outputs toggled %0d times and the noise register shifted %0d times.",
			tone_flips, noise_shifts);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("Verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timeout with %0d commands queued and %0d samples outstanding",
			pending_cmds.size(), expected_samples.size());
		$display("Verification failed");
		$finish;
	end

endmodule
